>>> design/fwrm_pkg.sv
// fwrm_pkg: shared types and constants for the firewall rule range match table
// used by fwrm_ctrl, fwrm_datapath and firewall_rule_range_match_table
`timescale 1ns / 1ps
`default_nettype none

package fwrm_pkg;

   localparam int OP_W      = 2;
   localparam int IP_W      = 32;
   localparam int PORT_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int HIT_OUT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_CHECK  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_FULL      = 3'd1,
      ST_INVALID   = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_ACCEPTED  = 3'd5,
      ST_REJECTED  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IP_W-1:0]   range_ip_start;
      logic [IP_W-1:0]   range_ip_end;
      logic [PORT_W-1:0] range_port_start;
      logic [PORT_W-1:0] range_port_end;
      logic [IP_W-1:0]   query_ip;
      logic [PORT_W-1:0] query_port;
   } req_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       do_add;
      logic       scan_start;
      logic       scan_step;
      logic       hit_write;
      logic       shift_start;
      logic       shift_step;
      logic       shift_write;
      logic       total_dec;
      logic       finish;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            well_formed;
      logic            table_empty;
      logic            table_full;
      logic            hit;
      logic            scan_last;
      logic            top_now;
      logic            top_next;
      logic            rsp_busy;
   } flag_type;

endpackage

`default_nettype wire

>>> design/firewall_rule_range_match_table.sv
// add, unknown ops, malformed deletes and deletes or checks on an empty table finish
// in decode; other requests read the rules newest first through the single
// registered read port of the rule memory, and a delete moves each newer rule down
// to close the gap; a request is accepted only in idle, once the last result is loaded
// reset: rule count and handshake state cleared, table empty, no clearing pass
// depends on fwrm_pkg, fwrm_ctrl and fwrm_datapath
`timescale 1ns / 1ps
`default_nettype none

module firewall_rule_range_match_table #(
   parameter int RULE_DEPTH = 64,
   parameter int HIT_LIMIT  = 100
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [fwrm_pkg::OP_W-1:0]             req_op,
   input  wire logic [fwrm_pkg::IP_W-1:0]             req_range_ip_start,
   input  wire logic [fwrm_pkg::IP_W-1:0]             req_range_ip_end,
   input  wire logic [fwrm_pkg::PORT_W-1:0]           req_range_port_start,
   input  wire logic [fwrm_pkg::PORT_W-1:0]           req_range_port_end,
   input  wire logic [fwrm_pkg::IP_W-1:0]             req_query_ip,
   input  wire logic [fwrm_pkg::PORT_W-1:0]           req_query_port,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [fwrm_pkg::STATUS_W-1:0]              rsp_status,
   output logic [fwrm_pkg::HIT_OUT_W-1:0]             rsp_hit_count
);
   import fwrm_pkg::*;

   req_type  req;
   cmd_type  cmd;
   flag_type flags;

   always_comb begin
      req.op               = req_op;
      req.range_ip_start   = req_range_ip_start;
      req.range_ip_end     = req_range_ip_end;
      req.range_port_start = req_range_port_start;
      req.range_port_end   = req_range_port_end;
      req.query_ip         = req_query_ip;
      req.query_port       = req_query_port;
   end

   fwrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   fwrm_datapath #(
      .RULE_DEPTH (RULE_DEPTH),
      .HIT_LIMIT  (HIT_LIMIT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .cmd           (cmd),
      .flags         (flags),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule

`default_nettype wire

>>> design/fwrm_ctrl.sv
// fwrm_ctrl: sequencing state machine for add, delete and check transactions
// depends on fwrm_pkg; drives fwrm_datapath through cmd_type
`timescale 1ns / 1ps
`default_nettype none

module fwrm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fwrm_pkg::flag_type flags,
   output fwrm_pkg::cmd_type      cmd
);
   import fwrm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_INVALID;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = ~reset;
            cmd.capture = req_valid & ~reset;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (flags.op)
               OP_ADD: begin
                  cmd.finish = 1'b1;
                  if (!flags.well_formed) begin
                     cmd.status = ST_INVALID;
                  end else if (flags.table_full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.do_add = 1'b1;
                     cmd.status = ST_ADDED;
                  end
               end
               OP_DELETE: begin
                  if (flags.table_empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_NOT_FOUND;
                  end else if (!flags.well_formed) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_INVALID;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               OP_CHECK: begin
                  if (flags.table_empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_REJECTED;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_INVALID;
               end
            endcase
         end
         S_SCAN: begin
            if (flags.hit) begin
               if (flags.op == OP_CHECK) begin
                  cmd.hit_write = 1'b1;
                  cmd.finish    = 1'b1;
                  cmd.status    = ST_ACCEPTED;
                  state_in      = S_DONE;
               end else if (flags.top_now) begin
                  cmd.total_dec = 1'b1;
                  cmd.finish    = 1'b1;
                  cmd.status    = ST_DELETED;
                  state_in      = S_DONE;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end
            end else if (flags.scan_last) begin
               cmd.finish = 1'b1;
               cmd.status = (flags.op == OP_CHECK) ? ST_REJECTED : ST_NOT_FOUND;
               state_in   = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift_write = 1'b1;
            if (flags.top_next) begin
               cmd.total_dec = 1'b1;
               cmd.finish    = 1'b1;
               cmd.status    = ST_DELETED;
               state_in      = S_DONE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!flags.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/fwrm_datapath.sv
// fwrm_datapath: rule memory, rule count, scan pointer, compares and response register
// depends on fwrm_pkg; commanded by fwrm_ctrl
`timescale 1ns / 1ps
`default_nettype none

module fwrm_datapath #(
   parameter int RULE_DEPTH = 64,
   parameter int HIT_LIMIT  = 100
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire fwrm_pkg::req_type                     req,
   input  wire fwrm_pkg::cmd_type                     cmd,
   output fwrm_pkg::flag_type                         flags,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [fwrm_pkg::STATUS_W-1:0]              rsp_status,
   output logic [fwrm_pkg::HIT_OUT_W-1:0]             rsp_hit_count
);
   import fwrm_pkg::*;

   localparam int AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CW    = $clog2(RULE_DEPTH + 1);
   localparam int HIT_W = $clog2(HIT_LIMIT + 1);

   typedef struct packed {
      logic [IP_W-1:0]   ip_start;
      logic [IP_W-1:0]   ip_end;
      logic [PORT_W-1:0] port_start;
      logic [PORT_W-1:0] port_end;
      logic [HIT_W-1:0]  hits;
   } entry_type;

   // oldest rule at address zero, newest at total - 1
   entry_type rule_mem_ff [RULE_DEPTH];
   entry_type rd_ff;

   req_type    req_ff, req_in;
   logic [CW-1:0] total_ff, total_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   status_type res_status_ff, res_status_in;
   logic [HIT_OUT_W-1:0] res_hits_ff, res_hits_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [HIT_OUT_W-1:0] rsp_hits_ff, rsp_hits_in;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] top_idx;
   logic          wr_en;
   entry_type     wr_data;
   logic [HIT_W-1:0] hits_next;
   logic          range_hit;
   logic          exact_hit;

   assign top_idx = AW'(total_ff - CW'(1));

   always_comb begin
      rd_addr = ptr_ff;
      ptr_in  = ptr_ff;
      if (cmd.scan_start) begin
         rd_addr = top_idx;
         ptr_in  = top_idx;
      end else if (cmd.scan_step) begin
         rd_addr = ptr_ff - AW'(1);
         ptr_in  = ptr_ff - AW'(1);
      end else if (cmd.shift_start) begin
         rd_addr = ptr_ff + AW'(1);
      end else if (cmd.shift_step) begin
         rd_addr = ptr_ff + AW'(2);
         ptr_in  = ptr_ff + AW'(1);
      end
   end

   assign hits_next = (rd_ff.hits < HIT_W'(HIT_LIMIT)) ? rd_ff.hits + HIT_W'(1) : rd_ff.hits;

   always_comb begin
      wr_en   = cmd.do_add | cmd.hit_write | cmd.shift_write;
      wr_addr = ptr_ff;
      wr_data = rd_ff;
      if (cmd.do_add) begin
         wr_addr            = total_ff[AW-1:0];
         wr_data.ip_start   = req_ff.range_ip_start;
         wr_data.ip_end     = req_ff.range_ip_end;
         wr_data.port_start = req_ff.range_port_start;
         wr_data.port_end   = req_ff.range_port_end;
         wr_data.hits       = '0;
      end else if (cmd.hit_write) begin
         wr_data.hits = hits_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= rule_mem_ff[rd_addr];
   end

   assign range_hit = (rd_ff.ip_start != '0) && (rd_ff.ip_end != '0)
      && (rd_ff.ip_start <= rd_ff.ip_end) && (rd_ff.port_start <= rd_ff.port_end)
      && (req_ff.query_ip >= rd_ff.ip_start) && (req_ff.query_ip <= rd_ff.ip_end)
      && (req_ff.query_port >= rd_ff.port_start) && (req_ff.query_port <= rd_ff.port_end);

   assign exact_hit = (rd_ff.ip_start == req_ff.range_ip_start)
      && (rd_ff.ip_end == req_ff.range_ip_end)
      && (rd_ff.port_start == req_ff.range_port_start)
      && (rd_ff.port_end == req_ff.range_port_end);

   always_comb begin
      flags.op          = req_ff.op;
      flags.well_formed = (req_ff.range_ip_start <= req_ff.range_ip_end)
                          && (req_ff.range_port_start <= req_ff.range_port_end);
      flags.table_empty = (total_ff == '0);
      flags.table_full  = (total_ff == CW'(RULE_DEPTH));
      flags.hit         = (req_ff.op == OP_CHECK) ? range_hit : exact_hit;
      flags.scan_last   = (ptr_ff == '0);
      flags.top_now     = ((CW'(ptr_ff) + CW'(1)) == total_ff);
      flags.top_next    = ((CW'(ptr_ff) + CW'(2)) == total_ff);
      flags.rsp_busy    = rsp_valid_ff & ~rsp_ready;
   end

   always_comb begin
      req_in        = cmd.capture ? req : req_ff;
      total_in      = total_ff;
      if (cmd.do_add) begin
         total_in = total_ff + CW'(1);
      end else if (cmd.total_dec) begin
         total_in = total_ff - CW'(1);
      end
      res_status_in = cmd.finish ? cmd.status : res_status_ff;
      res_hits_in   = res_hits_ff;
      if (cmd.finish) begin
         res_hits_in = cmd.hit_write ? HIT_OUT_W'(hits_next) : '0;
      end
      rsp_valid_in  = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
      rsp_status_in = cmd.rsp_load ? res_status_ff : rsp_status_ff;
      rsp_hits_in   = cmd.rsp_load ? res_hits_ff : rsp_hits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_hits_ff   <= res_hits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hits_ff   <= rsp_hits_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit_count = rsp_hits_ff;

endmodule

`default_nettype wire
